[hw/rtl/fms_pkg.sv]
// Shared constants, types, twiddle tables and helper functions for the FFT magnitude block.
package fms_pkg;

  localparam int POINTS   = 128;
  localparam int ADDR_W   = $clog2(POINTS);
  localparam int STAGES   = ADDR_W;
  localparam int STAGE_W  = $clog2(STAGES);
  localparam int HALF     = POINTS / 2;
  localparam int QUARTER  = POINTS / 4;
  localparam int GRP_W    = ADDR_W - 1;
  localparam int BINS     = (HALF > 64) ? 64 : HALF;
  localparam int BCNT_W   = $clog2(BINS);

  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 40;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = DATA_W + COEF_W;
  localparam int BIN_W    = 6;
  localparam int MAG_W    = 23;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef coef_t coef_rom_t [HALF];

  typedef enum logic [3:0] {
    S_LOAD,
    S_BF_RD,
    S_BF_MUL,
    S_BF_SUM,
    S_BF_WT,
    S_BF_WB,
    S_MAG_RD,
    S_MAG_GO,
    S_MAG_WAIT,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_we;
    logic [ADDR_W-1:0] load_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [GRP_W-1:0]  tw_idx;
    logic              mul_en;
    logic              sum_en;
    logic              wr_top;
    logic              wr_bot;
    logic              mag_start;
    logic              out_load;
    logic [BIN_W-1:0]  out_bin;
    logic              out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mag_busy;
    logic out_free;
  } status_t;

  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = v[ADDR_W-1-i];
    end
    return r;
  endfunction

  // Shift-and-subtract division; it only runs while the twiddle tables are built.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rest;
    quo  = 0;
    rest = 0;
    for (int i = 63; i >= 0; i--) begin
      rest = (rest << 1) | ((num >> i) & 64'd1);
      if (rest >= den) begin
        rest = rest - den;
        quo  = quo | (64'd1 << i);
      end
    end
    return quo;
  endfunction

  // Q30 Taylor series for an angle in the first quadrant.
  function automatic longint series_q30(input longint unsigned x, input bit sine);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned n;
    longint          sum;
    bit              neg;
    x2   = (x * x) >> 30;
    term = sine ? x : (64'd1 << 30);
    n    = sine ? 64'd1 : 64'd0;
    sum  = longint'(term);
    neg  = 1'b1;
    while (term != 0 && n < 40) begin
      term = div_u64((term * x2) >> 30, (n + 1) * (n + 2));
      n    = n + 2;
      sum  = neg ? sum - longint'(term) : sum + longint'(term);
      neg  = !neg;
    end
    return sum;
  endfunction

  function automatic longint q30_to_q16(input longint v);
    if (v < 0) return 0;
    return (v + 8192) >>> 14;
  endfunction

  function automatic coef_rom_t build_rom(input bit sine);
    coef_rom_t       rom;
    longint unsigned q;
    longint unsigned x;
    longint          val;
    bit              flip;
    for (int p = 0; p < HALF; p++) begin
      q    = longint'(p);
      flip = 1'b0;
      if (p > QUARTER) begin
        q    = longint'(HALF - p);
        flip = 1'b1;
      end
      x   = (2 * PI_Q30 * q + HALF) >> ADDR_W;
      val = q30_to_q16(series_q30(x, sine));
      if (!sine && flip) val = -val;
      rom[p] = COEF_W'(val);
    end
    return rom;
  endfunction

  localparam coef_rom_t COS_ROM = build_rom(1'b0);
  localparam coef_rom_t SIN_ROM = build_rom(1'b1);

endpackage

[hw/rtl/fms_if.sv]
// Handshake interfaces for the sample input channel and the spectrum output channel.
interface fms_in_if import fms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface fms_out_if import fms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] bin;
  logic [MAG_W-1:0] magnitude;
  logic             last_bin;

  modport source(output valid, output bin, output magnitude, output last_bin, input ready);
  modport sink(input valid, input bin, input magnitude, input last_bin, output ready);
endinterface

[hw/rtl/fft_magnitude_spectrum.sv]
// Top level of the 128-point radix-2 FFT magnitude spectrum block.
// Words are loaded while the source holds valid; the last word of a frame starts the transform.
// Each butterfly steps through read, multiply, sum, then two writes through the single
// write port of the sample store, for 448 butterflies. Each bin then steps through
// read, start, waiting on the magnitude unit (six partial products, a 24-step root), load.
// The load waits until the output register is free. Reset clears control and output valid, not the store.
module fft_magnitude_spectrum import fms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fms_in_if.sink    samples,
  fms_out_if.source spectrum
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences load, butterflies and bins; words are taken only while loading.
  fms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the store, the arithmetic and the output register, which lets the
  // next bin be computed while the previous word waits to be taken.
  fms_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .sample   (samples.sample),
    .cmd      (cmd),
    .status   (status),
    .spectrum (spectrum)
  );

endmodule

[hw/rtl/fms_mag.sv]
// Magnitude unit: squares by 20-bit partial products, then a bit-pair integer square root.
module fms_mag import fms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  data_t            re,
  input  data_t            im,
  output logic             busy,
  output logic [MAG_W-1:0] magnitude
);

  localparam int HW     = DATA_W / 2;
  localparam int ACC_W  = 2 * DATA_W;
  localparam int RAD_W  = ACC_W - 32;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 4;
  localparam int SQ_N   = 6;
  localparam int CNT_W  = $clog2(ROOT_W + 1);
  localparam logic [ROOT_W-1:0] MAG_MAX = ROOT_W'({MAG_W{1'b1}});

  logic [DATA_W-1:0] abs_re, abs_im;
  logic [ACC_W-1:0]  acc;
  logic              sq_phase;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;

  logic [DATA_W-1:0] op;
  logic [HW-1:0]     fa, fb;
  logic [2*HW-1:0]   prod;
  logic [ACC_W-1:0]  term;
  logic [REM_W-1:0]  rem_sh, trial;

  // Step order: re hh, re hl, re ll, im hh, im hl, im ll.
  always_comb begin
    op   = (cnt < CNT_W'(3)) ? abs_re : abs_im;
    fa   = op[DATA_W-1:HW];
    fb   = op[DATA_W-1:HW];
    term = '0;
    unique case (cnt)
      CNT_W'(0), CNT_W'(3): begin
        fa = op[DATA_W-1:HW];
        fb = op[DATA_W-1:HW];
      end
      CNT_W'(1), CNT_W'(4): begin
        fa = op[DATA_W-1:HW];
        fb = op[HW-1:0];
      end
      default: begin
        fa = op[HW-1:0];
        fb = op[HW-1:0];
      end
    endcase
    prod = fa * fb;
    unique case (cnt)
      CNT_W'(0), CNT_W'(3): term = ACC_W'(prod) << (2 * HW);
      CNT_W'(1), CNT_W'(4): term = ACC_W'(prod) << (HW + 1);
      default:              term = ACC_W'(prod);
    endcase
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial  = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sq_phase <= 1'b0;
      cnt      <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      sq_phase <= 1'b1;
      cnt      <= '0;
      abs_re   <= re[DATA_W-1] ? DATA_W'(-re) : DATA_W'(re);
      abs_im   <= im[DATA_W-1] ? DATA_W'(-im) : DATA_W'(im);
      acc      <= '0;
    end else if (busy && sq_phase) begin
      acc <= acc + term;
      if (cnt == CNT_W'(SQ_N - 1)) begin
        sq_phase <= 1'b0;
        cnt      <= '0;
        rem      <= '0;
        root     <= '0;
        rad      <= RAD_W'((acc + term) >> 32);
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (busy) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      if (cnt == CNT_W'(ROOT_W - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign magnitude = (root > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : root[MAG_W-1:0];

endmodule

[hw/rtl/fms_dp.sv]
// Datapath: sample store, butterfly arithmetic, magnitude unit and output register.
module fms_dp import fms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  cmd_t                       cmd,
  output status_t                    status,
  fms_out_if.source                  spectrum
);

  localparam int SUM_W = PROD_W + 1;
  localparam int T_W   = SUM_W - 16;
  localparam int OUT_W = T_W + 1;
  localparam logic signed [OUT_W-1:0] DMAX = OUT_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [OUT_W-1:0] DMIN = {{(OUT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic [2*DATA_W-1:0] mem [POINTS];
  logic [2*DATA_W-1:0] rdata_a, rdata_b;
  logic [ADDR_W-1:0]   addr_a_q, addr_b_q;
  coef_t               cos_q, sin_q;

  logic signed [PROD_W-1:0] p_rc, p_is, p_ic, p_rs;
  data_t                    top_re, top_im, bot_re, bot_im;

  data_t ar, ai, xr, xi;
  logic signed [SUM_W-1:0] t_sum, u_sum;
  logic signed [T_W-1:0]   t, u;

  logic             mag_busy;
  logic [MAG_W-1:0] mag_val;

  function automatic data_t sat(input logic signed [OUT_W-1:0] v);
    if (v > DMAX) return DMAX[DATA_W-1:0];
    if (v < DMIN) return DMIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  assign ar = rdata_a[2*DATA_W-1:DATA_W];
  assign ai = rdata_a[DATA_W-1:0];
  assign xr = rdata_b[2*DATA_W-1:DATA_W];
  assign xi = rdata_b[DATA_W-1:0];

  // Rounding is half up: add half an LSB, then drop sixteen bits arithmetically.
  always_comb begin
    t_sum = SUM_W'(p_rc) + SUM_W'(p_is) + SUM_W'(32768);
    u_sum = SUM_W'(p_ic) - SUM_W'(p_rs) + SUM_W'(32768);
    t     = t_sum[SUM_W-1:16];
    u     = u_sum[SUM_W-1:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem[cmd.load_addr] <= {{{(DATA_W-SAMPLE_W-16){sample[SAMPLE_W-1]}}, sample, 16'b0},
                             {DATA_W{1'b0}}};
    end else if (cmd.wr_top) begin
      mem[addr_a_q] <= {top_re, top_im};
    end else if (cmd.wr_bot) begin
      mem[addr_b_q] <= {bot_re, bot_im};
    end
    if (cmd.rd_en) begin
      rdata_a  <= mem[cmd.addr_a];
      rdata_b  <= mem[cmd.addr_b];
      addr_a_q <= cmd.addr_a;
      addr_b_q <= cmd.addr_b;
      cos_q    <= COS_ROM[cmd.tw_idx];
      sin_q    <= SIN_ROM[cmd.tw_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_rc <= xr * cos_q;
      p_is <= xi * sin_q;
      p_ic <= xi * cos_q;
      p_rs <= xr * sin_q;
    end
    if (cmd.sum_en) begin
      top_re <= sat(OUT_W'(ar) + OUT_W'(t));
      top_im <= sat(OUT_W'(ai) + OUT_W'(u));
      bot_re <= sat(OUT_W'(ar) - OUT_W'(t));
      bot_im <= sat(OUT_W'(ai) - OUT_W'(u));
    end
  end

  fms_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mag_start),
    .re        (ar),
    .im        (ai),
    .busy      (mag_busy),
    .magnitude (mag_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spectrum.valid <= 1'b0;
    end else if (cmd.out_load) begin
      spectrum.valid <= 1'b1;
    end else if (spectrum.ready) begin
      spectrum.valid <= 1'b0;
    end
    if (cmd.out_load) begin
      spectrum.bin       <= cmd.out_bin;
      spectrum.magnitude <= mag_val;
      spectrum.last_bin  <= cmd.out_last;
    end
  end

  assign status.mag_busy = mag_busy;
  assign status.out_free = !spectrum.valid || spectrum.ready;

endmodule

[hw/rtl/fms_ctrl.sv]
// Controller: frame loading, butterfly sequencing and per-bin magnitude sequencing.
module fms_ctrl import fms_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t              state, state_next;
  logic [ADDR_W-1:0]   load_count, load_count_next;
  logic [STAGE_W-1:0]  stage, stage_next;
  logic [GRP_W-1:0]    grp, grp_next;
  logic [BCNT_W-1:0]   bin, bin_next;

  logic [ADDR_W-1:0] gx, low_mask, k_top, k_bot;
  logic [STAGE_W-1:0] tw_shift;

  // Butterfly g of a stage with span b pairs k and k+b; within a stage the pairs are disjoint.
  always_comb begin
    gx       = ADDR_W'(grp);
    low_mask = (ADDR_W'(1) << stage) - ADDR_W'(1);
    k_top    = ((gx & ~low_mask) << 1) | (gx & low_mask);
    k_bot    = k_top | (ADDR_W'(1) << stage);
    tw_shift = STAGE_W'(STAGES - 1) - stage;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      stage      <= '0;
      grp        <= '0;
      bin        <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      stage      <= stage_next;
      grp        <= grp_next;
      bin        <= bin_next;
    end
  end

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    stage_next      = stage;
    grp_next        = grp;
    bin_next        = bin;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.load_addr   = bit_rev(load_count);
    cmd.addr_a      = k_top;
    cmd.addr_b      = k_bot;
    cmd.tw_idx      = GRP_W'((gx & low_mask) << tw_shift);
    cmd.out_bin     = BIN_W'(bin);
    cmd.out_last    = (bin == BCNT_W'(BINS - 1));
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_we     = 1'b1;
          load_count_next = load_count + 1'b1;
          if (load_count == ADDR_W'(POINTS - 1)) begin
            stage_next = '0;
            grp_next   = '0;
            state_next = S_BF_RD;
          end
        end
      end
      S_BF_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_BF_MUL;
      end
      S_BF_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_BF_SUM;
      end
      S_BF_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_BF_WT;
      end
      S_BF_WT: begin
        cmd.wr_top = 1'b1;
        state_next = S_BF_WB;
      end
      S_BF_WB: begin
        cmd.wr_bot = 1'b1;
        grp_next   = grp + 1'b1;
        state_next = S_BF_RD;
        if (grp == GRP_W'(HALF - 1)) begin
          stage_next = stage + 1'b1;
          if (stage == STAGE_W'(STAGES - 1)) begin
            bin_next   = '0;
            state_next = S_MAG_RD;
          end
        end
      end
      S_MAG_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.addr_a = ADDR_W'(bin);
        state_next = S_MAG_GO;
      end
      S_MAG_GO: begin
        cmd.mag_start = 1'b1;
        state_next    = S_MAG_WAIT;
      end
      S_MAG_WAIT: begin
        if (!status.mag_busy) state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (bin == BCNT_W'(BINS - 1)) begin
            state_next = S_LOAD;
          end else begin
            bin_next   = bin + 1'b1;
            state_next = S_MAG_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule
